### design/interval_set_table_top_macros.svh
// Assertion macros for the interval set table.
`ifndef INTERVAL_SET_TABLE_TOP_MACROS_SVH
`define INTERVAL_SET_TABLE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define IST_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define IST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IST_ASSERT_IMPLIES(label, ante, cons)
`define IST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### design/ist_pkg.sv
// Types and codes shared by the interval set table modules.
package ist_pkg;
	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_SINGLE = 3'd1;
	localparam logic [2:0] ACT_REMOVE = 3'd2;
	localparam logic [2:0] ACT_FIND   = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_BAD     = 2'd1;
	localparam logic [1:0] STAT_COVERED = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [30:0] range_low;
		logic [30:0] range_high;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
		logic [4:0] range_count;
	} out_item_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_SCAN_RD, S_SCAN_EV, S_SCAN_EV2,
		S_TAIL, S_COPY_RD, S_COPY_WR, S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic scan_ev;
		logic scan_ev2;
		logic tail;
		logic copy_wr;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic scan_empty;
		logic need2;
		logic last_scan;
		logic copy_go;
		logic last_copy;
		logic out_free;
	} dp_stat_t;
endpackage

### design/ist_ctrl.sv
// Sequencer for the interval set table: scan, tail, copy and result steps.
module ist_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ist_pkg::dp_stat_t st,
	output ist_pkg::cmd_t    cmd
);
	ist_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ist_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ist_pkg::S_IDLE: begin
				if (in_valid) state_nx = ist_pkg::S_DECIDE;
			end
			ist_pkg::S_DECIDE: begin
				if (!st.need_scan) state_nx = ist_pkg::S_DONE;
				else if (st.scan_empty) state_nx = ist_pkg::S_TAIL;
				else state_nx = ist_pkg::S_SCAN_RD;
			end
			ist_pkg::S_SCAN_RD: state_nx = ist_pkg::S_SCAN_EV;
			ist_pkg::S_SCAN_EV: begin
				if (st.need2) state_nx = ist_pkg::S_SCAN_EV2;
				else if (st.last_scan) state_nx = ist_pkg::S_TAIL;
				else state_nx = ist_pkg::S_SCAN_RD;
			end
			ist_pkg::S_SCAN_EV2: begin
				state_nx = st.last_scan ? ist_pkg::S_TAIL : ist_pkg::S_SCAN_RD;
			end
			ist_pkg::S_TAIL: begin
				state_nx = st.copy_go ? ist_pkg::S_COPY_RD : ist_pkg::S_DONE;
			end
			ist_pkg::S_COPY_RD: state_nx = ist_pkg::S_COPY_WR;
			ist_pkg::S_COPY_WR: begin
				state_nx = st.last_copy ? ist_pkg::S_DONE : ist_pkg::S_COPY_RD;
			end
			ist_pkg::S_DONE: begin
				if (st.out_free) state_nx = ist_pkg::S_IDLE;
			end
			default: state_nx = ist_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == ist_pkg::S_IDLE);
		cmd          = '0;
		cmd.load     = in_ready && in_valid;
		cmd.decide   = (state_q == ist_pkg::S_DECIDE);
		cmd.scan_ev  = (state_q == ist_pkg::S_SCAN_EV);
		cmd.scan_ev2 = (state_q == ist_pkg::S_SCAN_EV2);
		cmd.tail     = (state_q == ist_pkg::S_TAIL);
		cmd.copy_wr  = (state_q == ist_pkg::S_COPY_WR);
		cmd.emit     = (state_q == ist_pkg::S_DONE) && st.out_free;
	end
endmodule

### design/ist_dp.sv
// Datapath of the interval set table: range memories, scratch table, result register.
module ist_dp #(
	parameter int MAX_RANGES = 16,
	parameter int ID_BITS    = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ist_pkg::in_item_t   in_item,
	input  ist_pkg::cmd_t       cmd,
	output ist_pkg::dp_stat_t   st,
	output logic                out_valid,
	input  logic                out_ready,
	output ist_pkg::out_item_t  out_item
);
	localparam int DEPTH = MAX_RANGES + 2;
	localparam int AW    = $clog2(MAX_RANGES);
	localparam int SW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_RANGES + 3);
	localparam int UW    = $clog2(MAX_RANGES + 1);
	localparam int W1    = ID_BITS + 1;

	logic [ID_BITS-1:0] start_mem [MAX_RANGES];
	logic [ID_BITS-1:0] stop_mem  [MAX_RANGES];
	logic [ID_BITS-1:0] tmp_start_mem [DEPTH];
	logic [ID_BITS-1:0] tmp_stop_mem  [DEPTH];

	logic [2:0]         act_q;
	logic [ID_BITS-1:0] lo_q, hi_q, id_q;
	logic [ID_BITS-1:0] rs_q, re_q, cs_q, ce_q, ps_q, pe_q;
	logic [CW-1:0]      idx_q, n_q;
	logic [UW-1:0]      used_q;
	logic               placed_q, cov_q;
	logic [1:0]         res_status_q;
	logic               res_hit_q;
	logic               out_valid_q;
	ist_pkg::out_item_t out_item_q;

	logic [63:0]        lo64, hi64;
	logic               is_add, is_bad;
	logic [W1-1:0]      s1, e1, lo1, hi1;
	logic [ID_BITS-1:0] pa_s, pa_e, pb_s, pb_e, lo_n, hi_n;
	logic [1:0]         put_n;
	logic               placed_n, cov_hit;
	logic               wr_en;
	logic [ID_BITS-1:0] wr_s, wr_e;
	logic               add_put, commit_ok;
	logic [CW-1:0]      n_fin;
	logic [31:0]        used32;

	assign lo64   = 64'(in_item.range_low);
	assign hi64   = 64'(in_item.range_high);
	assign is_add = (act_q == ist_pkg::ACT_ADD) || (act_q == ist_pkg::ACT_SINGLE);
	assign is_bad = ((act_q == ist_pkg::ACT_ADD) || (act_q == ist_pkg::ACT_REMOVE))
		&& (lo_q > hi_q);

	// evaluate one stored range against the working range
	always_comb begin
		s1       = {1'b0, rs_q};
		e1       = {1'b0, re_q};
		lo1      = {1'b0, lo_q};
		hi1      = {1'b0, hi_q};
		pa_s     = rs_q;
		pa_e     = re_q;
		pb_s     = rs_q;
		pb_e     = re_q;
		put_n    = 2'd0;
		lo_n     = lo_q;
		hi_n     = hi_q;
		placed_n = placed_q;
		cov_hit  = (rs_q <= id_q) && (id_q <= re_q);
		if (is_add) begin
			if (e1 + W1'(1) < lo1) begin
				put_n = 2'd1;
			end else if (s1 > hi1 + W1'(1)) begin
				placed_n = 1'b1;
				if (!placed_q) begin
					pa_s  = lo_q;
					pa_e  = hi_q;
					put_n = 2'd2;
				end else begin
					put_n = 2'd1;
				end
			end else begin
				if (rs_q < lo_q) lo_n = rs_q;
				if (re_q > hi_q) hi_n = re_q;
			end
		end else if (act_q == ist_pkg::ACT_REMOVE) begin
			if ((re_q < lo_q) || (rs_q > hi_q)) begin
				put_n = 2'd1;
			end else if ((rs_q < lo_q) && (re_q > hi_q)) begin
				pa_e  = lo_q - ID_BITS'(1);
				pb_s  = hi_q + ID_BITS'(1);
				put_n = 2'd2;
			end else if (rs_q < lo_q) begin
				pa_e  = lo_q - ID_BITS'(1);
				put_n = 2'd1;
			end else if (re_q > hi_q) begin
				pa_s  = hi_q + ID_BITS'(1);
				put_n = 2'd1;
			end
		end
	end

	assign add_put   = is_add && !placed_q;
	assign n_fin     = n_q + CW'(add_put);
	assign commit_ok = ((act_q == ist_pkg::ACT_ADD) || (act_q == ist_pkg::ACT_REMOVE)
		|| ((act_q == ist_pkg::ACT_SINGLE) && !cov_q)) && (n_fin <= CW'(MAX_RANGES));

	always_comb begin
		wr_en = 1'b0;
		wr_s  = pa_s;
		wr_e  = pa_e;
		if (cmd.scan_ev) begin
			wr_en = (put_n != 2'd0) && (act_q != ist_pkg::ACT_FIND);
		end else if (cmd.scan_ev2) begin
			wr_en = 1'b1;
			wr_s  = ps_q;
			wr_e  = pe_q;
		end else if (cmd.tail) begin
			wr_en = add_put;
			wr_s  = lo_q;
			wr_e  = hi_q;
		end
		if (n_q >= CW'(DEPTH)) wr_en = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tmp_start_mem[n_q[SW-1:0]] <= wr_s;
			tmp_stop_mem[n_q[SW-1:0]]  <= wr_e;
		end
		cs_q <= tmp_start_mem[idx_q[SW-1:0]];
		ce_q <= tmp_stop_mem[idx_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.copy_wr) begin
			start_mem[idx_q[AW-1:0]] <= cs_q;
			stop_mem[idx_q[AW-1:0]]  <= ce_q;
		end
		rs_q <= start_mem[idx_q[AW-1:0]];
		re_q <= stop_mem[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_item.action;
			lo_q  <= lo64[ID_BITS-1:0];
			id_q  <= lo64[ID_BITS-1:0];
			hi_q  <= (in_item.action == ist_pkg::ACT_SINGLE) ? lo64[ID_BITS-1:0]
				: hi64[ID_BITS-1:0];
		end else if (cmd.scan_ev) begin
			lo_q <= lo_n;
			hi_q <= hi_n;
			ps_q <= pb_s;
			pe_q <= pb_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			n_q          <= '0;
			used_q       <= '0;
			placed_q     <= 1'b0;
			cov_q        <= 1'b0;
			res_status_q <= ist_pkg::STAT_OK;
			res_hit_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q    <= '0;
				n_q      <= '0;
				placed_q <= 1'b0;
				cov_q    <= 1'b0;
			end
			if (cmd.decide) begin
				res_hit_q    <= 1'b0;
				res_status_q <= is_bad ? ist_pkg::STAT_BAD : ist_pkg::STAT_OK;
				if (act_q == ist_pkg::ACT_CLEAR) used_q <= '0;
			end
			if (cmd.scan_ev) begin
				placed_q <= placed_n;
				cov_q    <= cov_q | cov_hit;
				if (act_q != ist_pkg::ACT_FIND) n_q <= n_q + CW'(put_n != 2'd0);
				if (put_n != 2'd2) idx_q <= idx_q + CW'(1);
			end
			if (cmd.scan_ev2) begin
				n_q   <= n_q + CW'(1);
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.tail) begin
				idx_q <= '0;
				n_q   <= n_fin;
				if (act_q == ist_pkg::ACT_FIND) begin
					res_hit_q <= cov_q;
				end else if ((act_q == ist_pkg::ACT_SINGLE) && cov_q) begin
					res_status_q <= ist_pkg::STAT_COVERED;
				end else if (!commit_ok) begin
					res_status_q <= ist_pkg::STAT_FULL;
				end else if (n_fin == '0) begin
					used_q <= '0;
				end
			end
			if (cmd.copy_wr) begin
				idx_q <= idx_q + CW'(1);
				if (st.last_copy) used_q <= UW'(n_q);
			end
		end
	end

	assign used32 = 32'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_item_q.status      <= res_status_q;
			out_item_q.hit         <= res_hit_q;
			out_item_q.range_count <= used32[4:0];
		end
	end

	always_comb begin
		st            = '0;
		st.need_scan  = !is_bad && (act_q <= ist_pkg::ACT_FIND);
		st.scan_empty = (used_q == '0);
		st.need2      = (put_n == 2'd2) && (act_q != ist_pkg::ACT_FIND);
		st.last_scan  = (CW'(used_q) <= idx_q + CW'(1));
		st.copy_go    = commit_ok && (n_fin != '0)
			&& !(act_q == ist_pkg::ACT_FIND);
		st.last_copy  = (n_q <= idx_q + CW'(1));
		st.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
endmodule

### design/interval_set_table_top.sv
// Interval set table top level: sorted disjoint id ranges with add, remove, find, clear.
// Sequence: clear, bad bounds and unused codes go from decide straight to the result; else
//   the stored ranges are read and evaluated one by one, then on commit the scratch table
//   is copied back, with an extra write per range inserted or split; one read port per table.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: arst_n clears the range count and handshake state; range memories hold no reset.
`include "interval_set_table_top_macros.svh"
module interval_set_table_top #(
	parameter int MAX_RANGES = 16,
	parameter int ID_BITS    = 31
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ist_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output ist_pkg::out_item_t out_item
);
	ist_pkg::cmd_t     cmd;
	ist_pkg::dp_stat_t st;

	// sequencer: walks the stored ranges, then the scratch table on commit
	ist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: merge/split evaluation, memories, result register
	ist_dp #(
		.MAX_RANGES (MAX_RANGES),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// hold off further items while one is in flight
	`IST_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)
	// a hit only comes from a successful find
	`IST_ASSERT_IMPLIES(a_hit_ok, out_valid && out_item.hit, out_item.status == ist_pkg::STAT_OK)
	// the reported count never exceeds the table size
	`IST_ASSERT_IMPLIES(a_count_max, out_valid, 32'(out_item.range_count) <= MAX_RANGES)
endmodule

### bench/interval_set_table_top_tb.sv
// Self-checking bench for the interval set table: directed and random add, remove, find, clear.
`timescale 1ns / 1ps
module interval_set_table_top_tb;
	localparam int TABLE_DEPTH = 16;
	localparam int STALL_LIMIT = 20000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	ist_pkg::in_item_t  in_item = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ist_pkg::out_item_t out_item;

	// Model of the table: sorted disjoint, non-touching inclusive ranges
	logic [30:0]        span_lo[$];
	logic [30:0]        span_hi[$];
	ist_pkg::out_item_t pending_answers[$];

	int  failures = 0;
	int  items_sent = 0;
	int  answers_seen = 0;
	int  idle_cycles = 0;
	bit  no_idle = 1'b0;
	int  n_full = 0;
	int  n_covered = 0;
	int  n_bad = 0;

	interval_set_table_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always #1 clk = ~clk;

	function automatic bit id_covered(logic [30:0] id);
		foreach (span_lo[i])
			if (span_lo[i] <= id && id <= span_hi[i])
				return 1'b1;
		return 1'b0;
	endfunction

	// Union of [lo,hi] with every range it overlaps or touches; 64-bit math avoids wrap
	function automatic logic [1:0] merge_span(logic [30:0] lo_in, logic [30:0] hi_in);
		longint lo, hi;
		logic [30:0] nlo[$];
		logic [30:0] nhi[$];
		bit placed;
		lo = lo_in;
		hi = hi_in;
		placed = 1'b0;
		foreach (span_lo[i]) begin
			if (longint'(span_hi[i]) + 1 < lo) begin
				nlo.push_back(span_lo[i]); nhi.push_back(span_hi[i]);
			end else if (longint'(span_lo[i]) > hi + 1) begin
				if (!placed) begin
					nlo.push_back(lo[30:0]); nhi.push_back(hi[30:0]); placed = 1'b1;
				end
				nlo.push_back(span_lo[i]); nhi.push_back(span_hi[i]);
			end else begin
				if (span_lo[i] < lo) lo = span_lo[i];
				if (span_hi[i] > hi) hi = span_hi[i];
			end
		end
		if (!placed) begin
			nlo.push_back(lo[30:0]); nhi.push_back(hi[30:0]);
		end
		if (nlo.size() > TABLE_DEPTH)
			return ist_pkg::STAT_FULL;
		span_lo = nlo;
		span_hi = nhi;
		return ist_pkg::STAT_OK;
	endfunction

	// Subtract [lo,hi], trimming or splitting the edge ranges
	function automatic logic [1:0] carve_span(logic [30:0] lo, logic [30:0] hi);
		logic [30:0] nlo[$];
		logic [30:0] nhi[$];
		foreach (span_lo[i]) begin
			if (span_hi[i] < lo || span_lo[i] > hi) begin
				nlo.push_back(span_lo[i]); nhi.push_back(span_hi[i]);
			end else begin
				if (span_lo[i] < lo) begin
					nlo.push_back(span_lo[i]); nhi.push_back(lo - 31'd1);
				end
				if (span_hi[i] > hi) begin
					nlo.push_back(hi + 31'd1); nhi.push_back(span_hi[i]);
				end
			end
		end
		if (nlo.size() > TABLE_DEPTH)
			return ist_pkg::STAT_FULL;
		span_lo = nlo;
		span_hi = nhi;
		return ist_pkg::STAT_OK;
	endfunction

	function automatic ist_pkg::out_item_t apply_request(ist_pkg::in_item_t req);
		ist_pkg::out_item_t ans;
		ans = '0;
		case (req.action)
			ist_pkg::ACT_ADD: ans.status = (req.range_low > req.range_high)
				? ist_pkg::STAT_BAD : merge_span(req.range_low, req.range_high);
			ist_pkg::ACT_SINGLE: ans.status = id_covered(req.range_low)
				? ist_pkg::STAT_COVERED : merge_span(req.range_low, req.range_low);
			ist_pkg::ACT_REMOVE: ans.status = (req.range_low > req.range_high)
				? ist_pkg::STAT_BAD : carve_span(req.range_low, req.range_high);
			ist_pkg::ACT_FIND: ans.hit = id_covered(req.range_low);
			ist_pkg::ACT_CLEAR: begin
				span_lo.delete();
				span_hi.delete();
			end
			default: ;
		endcase
		ans.range_count = 5'(span_lo.size());
		return ans;
	endfunction

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < 33);
	endfunction

	// Present one item, optionally after a random gap; hold until accepted
	task automatic send_request(logic [2:0] act, logic [30:0] lo, logic [30:0] hi);
		ist_pkg::in_item_t req;
		req.action = act;
		req.range_low = lo;
		req.range_high = hi;
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_item <= req;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_answers.push_back(apply_request(req));
		case (pending_answers[$].status)
			ist_pkg::STAT_FULL: n_full++;
			ist_pkg::STAT_COVERED: n_covered++;
			ist_pkg::STAT_BAD: n_bad++;
			default: ;
		endcase
		items_sent++;
		@(negedge clk);
	endtask

	// Drop the input and wait until every expected result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
	endtask

	// Random result-side stall, decided each falling edge
	always @(negedge clk)
		if (arst_n)
			out_ready <= !idle_now();

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		ist_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				$error("unexpected result %p", out_item);
				failures++;
			end else begin
				want = pending_answers.pop_front();
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, out_item.status);
					failures++;
				end
				if (out_item.hit !== want.hit) begin
					$error("hit: expected %0d, actual %0d", want.hit, out_item.hit);
					failures++;
				end
				if (out_item.range_count !== want.range_count) begin
					$error("range_count: expected %0d, actual %0d",
						want.range_count, out_item.range_count);
					failures++;
				end
			end
		end
	end

	// Watchdog: count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no progress for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [30:0] rand_id();
		return 31'($urandom());
	endfunction

	// Field extremes, every action, bad bounds, unused codes
	task automatic test_directed();
		send_request(ist_pkg::ACT_FIND, 31'd0, 31'd0);
		send_request(ist_pkg::ACT_ADD, 31'd0, 31'd0);
		send_request(ist_pkg::ACT_ADD, 31'h7fffffff, 31'h7fffffff);
		send_request(ist_pkg::ACT_ADD, 31'd10, 31'd5);
		send_request(ist_pkg::ACT_REMOVE, 31'd10, 31'd5);
		send_request(ist_pkg::ACT_SINGLE, 31'd0, 31'h7fffffff);
		send_request(ist_pkg::ACT_SINGLE, 31'd1, 31'd0);
		send_request(ist_pkg::ACT_FIND, 31'h7fffffff, 31'd0);
		send_request(ist_pkg::ACT_FIND, 31'h55555555, 31'h2aaaaaaa);
		send_request(ist_pkg::ACT_ADD, 31'd100, 31'd200);
		send_request(ist_pkg::ACT_ADD, 31'd201, 31'd300);
		send_request(ist_pkg::ACT_ADD, 31'd50, 31'd99);
		send_request(ist_pkg::ACT_ADD, 31'd150, 31'd250);
		send_request(ist_pkg::ACT_REMOVE, 31'd120, 31'd130);
		send_request(ist_pkg::ACT_REMOVE, 31'd40, 31'd60);
		send_request(ist_pkg::ACT_REMOVE, 31'd0, 31'h7fffffff);
		send_request(3'd5, 31'h7fffffff, 31'h7fffffff);
		send_request(3'd6, 31'd1, 31'd2);
		send_request(3'd7, 31'h2aaaaaaa, 31'h55555555);
		send_request(ist_pkg::ACT_ADD, 31'd0, 31'h7fffffff);
		send_request(ist_pkg::ACT_CLEAR, 31'h7fffffff, 31'h7fffffff);
	endtask

	// Fill the table to capacity, then overflow on a single-id add and on a splitting remove
	task automatic test_table_full();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_request(ist_pkg::ACT_ADD, 31'(i * 4), 31'(i * 4 + 2));
		send_request(ist_pkg::ACT_SINGLE, 31'd1000, 31'd0);
		send_request(ist_pkg::ACT_SINGLE, 31'd8, 31'd0);
		send_request(ist_pkg::ACT_REMOVE, 31'd9, 31'd9);
		send_request(ist_pkg::ACT_ADD, 31'd3, 31'd3);
		send_request(ist_pkg::ACT_REMOVE, 31'd61, 31'd61);
		send_request(ist_pkg::ACT_REMOVE, 31'd8, 31'd8);
		send_request(ist_pkg::ACT_CLEAR, 31'd0, 31'd0);
		// hold off until the table side is fully drained
		wait_drained();
	endtask

	// Mostly a small id window so ranges collide; a few full-width ids
	task automatic test_random(int count, int window);
		logic [2:0]  act;
		logic [30:0] lo, hi;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 35)      act = ist_pkg::ACT_ADD;
			else if (pick < 55) act = ist_pkg::ACT_SINGLE;
			else if (pick < 75) act = ist_pkg::ACT_REMOVE;
			else if (pick < 95) act = ist_pkg::ACT_FIND;
			else if (pick < 98) act = ist_pkg::ACT_CLEAR;
			else                act = 3'($urandom_range(7, 5));
			if ($urandom_range(19) == 0) begin
				lo = rand_id();
				hi = rand_id();
			end else begin
				lo = 31'($urandom_range(window));
				hi = ($urandom_range(9) == 0) ? 31'($urandom_range(window))
					: lo + 31'($urandom_range(window / 16));
			end
			send_request(act, lo, hi);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_random(600, 200);
		no_idle = 1'b1;
		test_random(300, 1000);
		no_idle = 1'b0;
		wait_drained();
		test_random(900, 120);
		wait_drained();
		repeat (100) @(negedge clk);
		$display("sent %0d items, checked %0d results", items_sent, answers_seen);
		$display("table full %0d, already covered %0d, bad bounds %0d",
			n_full, n_covered, n_bad);
		if (failures == 0 && pending_answers.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### filelist.f
+incdir+design
design/ist_pkg.sv
design/ist_ctrl.sv
design/ist_dp.sv
design/interval_set_table_top.sv
bench/interval_set_table_top_tb.sv
